[rtl/core/interval_seat_allocator_top_macros.svh]
// assertion macros used by the allocator placer
`ifndef INTERVAL_SEAT_ALLOCATOR_TOP_MACROS_SVH
`define INTERVAL_SEAT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define ISA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/isa_pkg.sv]
// ----------------------------------------------------------------------------
// isa_pkg
// constants and types of the interval seat allocator
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int MAX_ITEMS  = 256;
    localparam int MAX_SEATS  = 32;
    localparam int TIME_BITS  = 24;

    localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int SEAT_AW    = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
    localparam int SEAT_CNT_W = $clog2(MAX_SEATS + 1);
    localparam int SEATNUM_W  = 6;
    localparam int USAGE_W    = 9;
    localparam int KEY_W      = 2 * TIME_BITS + IDX_W;

    localparam logic [USAGE_W-1:0] USAGE_MAX = {USAGE_W{1'b1}};

    typedef logic [KEY_W-1:0] key_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] start_time;
        logic [TIME_BITS-1:0] end_time;
        logic                 last_item;
    } iv_t;

endpackage

[rtl/core/isa_in_if.sv]
// ----------------------------------------------------------------------------
// isa_in_if
// interval item channel
// ----------------------------------------------------------------------------
interface isa_in_if import isa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic                 last_item;

    modport source (output valid, start_time, end_time, last_item, input ready);
    modport sink   (input valid, start_time, end_time, last_item, output ready);
endinterface

[rtl/core/isa_out_if.sv]
// ----------------------------------------------------------------------------
// isa_out_if
// result item channel
// ----------------------------------------------------------------------------
interface isa_out_if import isa_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [SEATNUM_W-1:0] seat_number;
    logic [USAGE_W-1:0]   value;
    logic                 overflow;
    logic                 last_result;

    modport source (output valid, seat_number, value, overflow, last_result, input ready);
    modport sink   (input valid, seat_number, value, overflow, last_result, output ready);
endinterface

[rtl/core/isa_sorter.sv]
// ----------------------------------------------------------------------------
// isa_sorter
// interval memory; loads items, then hands them out in start/end order
// by repeated minimum scans over the memory
// ----------------------------------------------------------------------------
module isa_sorter import isa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    isa_in_if.sink intake,
    output iv_t   iv,
    output logic  iv_valid,
    input  logic  iv_ready
);

    localparam logic [1:0] S_LOAD = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SEND = 2'd2;

    logic [2*TIME_BITS-1:0] mem [MAX_ITEMS];
    logic [2*TIME_BITS-1:0] rd_data_reg;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] sent_reg, sent_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             best_valid_reg, best_valid_next;
    key_t             best_reg, best_next;
    logic             prev_valid_reg, prev_valid_next;
    key_t             prev_reg, prev_next;

    logic load_acc, wr_en, rd_en, take, send_last;
    key_t cand;

    assign intake.ready = (state_reg == S_LOAD);
    assign load_acc     = intake.valid && intake.ready;
    assign wr_en        = load_acc && (cnt_reg < CNT_W'(MAX_ITEMS));
    assign rd_en        = (state_reg == S_SCAN) && (scan_reg < cnt_reg);
    assign cand         = {rd_data_reg, rd_idx_reg};
    assign take         = rd_pend_reg && (!prev_valid_reg || (cand > prev_reg))
                          && (!best_valid_reg || (cand < best_reg));
    assign send_last    = (sent_reg + CNT_W'(1)) == cnt_reg;

    assign iv_valid      = (state_reg == S_SEND);
    assign iv.start_time = best_reg[KEY_W-1 -: TIME_BITS];
    assign iv.end_time   = best_reg[IDX_W +: TIME_BITS];
    assign iv.last_item  = send_last;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        sent_next       = sent_reg;
        rd_pend_next    = rd_en;
        rd_idx_next     = scan_reg[IDX_W-1:0];
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        prev_valid_next = prev_valid_reg;
        prev_next       = prev_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (wr_en)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                if (load_acc && intake.last_item)
                begin
                    state_next      = S_SCAN;
                    scan_next       = '0;
                    sent_next       = '0;
                    best_valid_next = 1'b0;
                    prev_valid_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
                if (take)
                begin
                    best_next       = cand;
                    best_valid_next = 1'b1;
                end
                if (!rd_en && !rd_pend_reg)
                begin
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                if (iv_ready)
                begin
                    prev_next       = best_reg;
                    prev_valid_next = 1'b1;
                    sent_next       = sent_reg + CNT_W'(1);
                    best_valid_next = 1'b0;
                    scan_next       = '0;
                    if (send_last)
                    begin
                        state_next = S_LOAD;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            cnt_reg        <= '0;
            scan_reg       <= '0;
            sent_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            scan_reg       <= scan_next;
            sent_reg       <= sent_next;
            rd_pend_reg    <= rd_pend_next;
            best_valid_reg <= best_valid_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        best_reg   <= best_next;
        prev_reg   <= prev_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= {intake.start_time, intake.end_time};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_reg[IDX_W-1:0]];
        end
    end

endmodule

[rtl/core/isa_placer.sv]
// ----------------------------------------------------------------------------
// isa_placer
// seat memory; places ordered intervals on the lowest free seat and
// emits the seat count and per-seat usage
// ----------------------------------------------------------------------------
module isa_placer import isa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  iv_t   iv,
    input  logic  iv_valid,
    output logic  iv_ready,
    isa_out_if.source result
);
    `include "interval_seat_allocator_top_macros.svh"

    localparam logic [2:0] P_IDLE    = 3'd0;
    localparam logic [2:0] P_RD      = 3'd1;
    localparam logic [2:0] P_CHK     = 3'd2;
    localparam logic [2:0] P_OPEN    = 3'd3;
    localparam logic [2:0] P_HEAD    = 3'd4;
    localparam logic [2:0] P_EMIT_RD = 3'd5;
    localparam logic [2:0] P_EMIT_WR = 3'd6;

    localparam int SEAT_DW = USAGE_W + TIME_BITS;

    logic [SEAT_DW-1:0] seat_mem [MAX_SEATS];
    logic [SEAT_DW-1:0] rd_data_reg;

    logic [2:0]            state_reg, state_next;
    logic [SEAT_CNT_W-1:0] opened_reg, opened_next;
    logic                  ovf_reg, ovf_next;
    logic [SEAT_CNT_W-1:0] seat_reg, seat_next;
    iv_t                   cur_reg, cur_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SEATNUM_W-1:0]  out_seat_reg, out_seat_next;
    logic [USAGE_W-1:0]    out_value_reg, out_value_next;
    logic                  out_ovf_reg, out_ovf_next;
    logic                  out_last_reg, out_last_next;

    logic                  rd_en, wr_en, out_free;
    logic [SEAT_AW-1:0]    rd_addr, wr_addr;
    logic [SEAT_DW-1:0]    wr_data;
    logic [USAGE_W-1:0]    rd_usage;
    logic [TIME_BITS-1:0]  rd_busy;
    logic [SEAT_CNT_W-1:0] seat_inc;

    assign iv_ready = (state_reg == P_IDLE);
    assign out_free = !out_valid_reg || result.ready;
    assign rd_usage = rd_data_reg[SEAT_DW-1 -: USAGE_W];
    assign rd_busy  = rd_data_reg[TIME_BITS-1:0];
    assign seat_inc = seat_reg + SEAT_CNT_W'(1);
    assign rd_en    = (state_reg == P_RD) || ((state_reg == P_EMIT_RD) && out_free);
    assign rd_addr  = seat_reg[SEAT_AW-1:0];

    assign result.valid       = out_valid_reg;
    assign result.seat_number = out_seat_reg;
    assign result.value       = out_value_reg;
    assign result.overflow    = out_ovf_reg;
    assign result.last_result = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        opened_next    = opened_reg;
        ovf_next       = ovf_reg;
        seat_next      = seat_reg;
        cur_next       = cur_reg;
        wr_en          = 1'b0;
        wr_addr        = seat_reg[SEAT_AW-1:0];
        wr_data        = '0;
        out_valid_next = out_valid_reg && !result.ready;
        out_seat_next  = out_seat_reg;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (iv_valid)
                begin
                    cur_next   = iv;
                    seat_next  = '0;
                    state_next = (opened_reg == '0) ? P_OPEN : P_RD;
                end
            end
            P_RD:
            begin
                state_next = P_CHK;
            end
            P_CHK:
            begin
                if (rd_busy <= cur_reg.start_time)
                begin
                    wr_en   = 1'b1;
                    wr_data = {(rd_usage == USAGE_MAX) ? rd_usage
                                                       : rd_usage + USAGE_W'(1),
                               cur_reg.end_time};
                    state_next = cur_reg.last_item ? P_HEAD : P_IDLE;
                end
                else if (seat_inc == opened_reg)
                begin
                    state_next = P_OPEN;
                end
                else
                begin
                    seat_next  = seat_inc;
                    state_next = P_RD;
                end
            end
            P_OPEN:
            begin
                if (opened_reg < SEAT_CNT_W'(MAX_SEATS))
                begin
                    wr_en       = 1'b1;
                    wr_addr     = opened_reg[SEAT_AW-1:0];
                    wr_data     = {USAGE_W'(1), cur_reg.end_time};
                    opened_next = opened_reg + SEAT_CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = cur_reg.last_item ? P_HEAD : P_IDLE;
            end
            P_HEAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_seat_next  = '0;
                    out_value_next = USAGE_W'(opened_reg);
                    out_ovf_next   = ovf_reg;
                    out_last_next  = (opened_reg == '0);
                    seat_next      = '0;
                    if (opened_reg == '0)
                    begin
                        ovf_next   = 1'b0;
                        state_next = P_IDLE;
                    end
                    else
                    begin
                        state_next = P_EMIT_RD;
                    end
                end
            end
            P_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = P_EMIT_WR;
                end
            end
            P_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_seat_next  = SEATNUM_W'(seat_inc);
                    out_value_next = rd_usage;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = (seat_inc == opened_reg);
                    if (seat_inc == opened_reg)
                    begin
                        opened_next = '0;
                        ovf_next    = 1'b0;
                        state_next  = P_IDLE;
                    end
                    else
                    begin
                        seat_next  = seat_inc;
                        state_next = P_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= P_IDLE;
            opened_reg    <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            opened_reg    <= opened_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seat_reg      <= seat_next;
        cur_reg       <= cur_next;
        out_seat_reg  <= out_seat_next;
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seat_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= seat_mem[rd_addr];
        end
    end

    `ISA_ASSERT_NOW(a_open_limit, 1'b1, opened_reg <= SEAT_CNT_W'(MAX_SEATS), "seats over limit")
    `ISA_ASSERT_NEXT(a_open_inc, (state_reg == P_OPEN) && (opened_reg < SEAT_CNT_W'(MAX_SEATS)), opened_reg == $past(opened_reg) + SEAT_CNT_W'(1), "open did not count")
    `ISA_ASSERT_NOW(a_emit_range, state_reg == P_EMIT_WR, seat_reg < opened_reg, "emit past opened seats")

endmodule

[rtl/core/interval_seat_allocator_top.sv]
// ----------------------------------------------------------------------------
// interval_seat_allocator_top
// interval partitioning onto the lowest free seat
//
//   channel   dir   payload
//   intake    in    start_time, end_time, last_item
//   result    out   seat_number, value, overflow, last_result
//
// loading takes one item per cycle into the interval memory
// after the last item, each ordered interval costs one scan over the
// interval memory plus a hand-off, then a read and a check for each
// seat tried on the seat memory
// the seat count and per-seat usage follow, held while result is not ready
// intake stalls from the last item until the final interval is handed off
// reset is asynchronous, active low; no clearing pass
// ----------------------------------------------------------------------------
module interval_seat_allocator_top import isa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    isa_in_if.sink     intake,
    isa_out_if.source  result
);

    iv_t  iv;
    logic iv_valid;
    logic iv_ready;

    isa_sorter u_sorter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .intake   (intake),
        .iv       (iv),
        .iv_valid (iv_valid),
        .iv_ready (iv_ready)
    );

    isa_placer u_placer
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .iv       (iv),
        .iv_valid (iv_valid),
        .iv_ready (iv_ready),
        .result   (result)
    );

endmodule
